// ----- rtl/swpf_pkg.sv -----
// Shared types and constants of the servo write packet framer.
package swpf_pkg;

	localparam int DVD_W = 25;
	localparam int DVS_W = 21;
	localparam int DCNT_W = 5;

	localparam logic [7:0] HDR_BYTE = 8'hFF;
	localparam logic [7:0] OP_WRITE = 8'h03;
	localparam logic [7:0] ADDR_GOAL = 8'h1E;
	localparam logic [7:0] ADDR_BAUD = 8'h04;
	localparam logic [7:0] ADDR_ID = 8'h03;
	localparam logic [7:0] LEN_ONE = 8'h04;
	localparam logic [7:0] LEN_TWO = 8'h05;
	localparam logic [3:0] NBYTES_ONE = 4'd8;
	localparam logic [3:0] NBYTES_TWO = 4'd9;

	localparam logic [9:0] POS_MAX = 10'd1023;
	localparam logic [7:0] CODE_MAX = 8'd255;
	localparam logic [7:0] CODE_DEFAULT = 8'd1;
	localparam logic [DVS_W-1:0] POS_DIVISOR = 21'd30000;
	localparam logic [DVD_W-1:0] BAUD_NUM = 25'd2000000;
	localparam logic [7:0] MOTOR_ID_RESET = 8'd1;

	localparam logic [1:0] ACT_POS = 2'd0;
	localparam logic [1:0] ACT_BAUD = 2'd1;
	localparam logic [1:0] ACT_ID = 2'd2;
	localparam logic [1:0] ACT_NONE = 2'd3;

	localparam logic REG_MOTOR_ID = 1'b0;

	typedef struct packed {
		logic [7:0] id;
		logic [7:0] addr;
		logic [7:0] data0;
		logic [7:0] data1;
		logic two_data;
	} pkt_load_t;

endpackage

// ----- rtl/swpf_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
module swpf_div import swpf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [DVD_W-1:0] dividend,
	input logic [DVS_W-1:0] divisor,
	output logic done,
	output logic [DVD_W-1:0] quotient
);

	logic busy_q;
	logic done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W:0] trial;
	logic [DVS_W:0] diff;
	logic ge;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign diff = trial - {1'b0, dvs_q};
	assign ge = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= DCNT_W'(DVD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

// ----- rtl/swpf_ser.sv -----
// Byte serializer of one packet with running checksum.
module swpf_ser import swpf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic load,
	input pkt_load_t load_info,
	output logic pkt_valid,
	input logic pkt_stall,
	output logic [7:0] tx_byte,
	output logic last_byte,
	output logic done
);

	logic active_q;
	logic [63:0] sh_q;
	logic [3:0] idx_q;
	logic [3:0] n_q;
	logic [7:0] sum_q;
	logic take;
	logic is_last;

	assign is_last = (idx_q == (n_q - 4'd1));
	assign take = active_q && !pkt_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q <= '0;
			n_q <= NBYTES_ONE;
			sum_q <= '0;
		end else if (load) begin
			active_q <= 1'b1;
			idx_q <= '0;
			n_q <= load_info.two_data ? NBYTES_TWO : NBYTES_ONE;
			sum_q <= '0;
		end else if (take) begin
			idx_q <= idx_q + 4'd1;
			if (idx_q >= 4'd2) begin
				sum_q <= sum_q + sh_q[63:56];
			end
			if (is_last) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sh_q <= {HDR_BYTE, HDR_BYTE, load_info.id,
				load_info.two_data ? LEN_TWO : LEN_ONE,
				OP_WRITE, load_info.addr, load_info.data0, load_info.data1};
		end else if (take) begin
			sh_q <= {sh_q[55:0], 8'h00};
		end
	end

	assign pkt_valid = active_q;
	assign last_byte = is_last;
	assign tx_byte = is_last ? ~sum_q : sh_q[63:56];
	assign done = take && is_last;

endmodule

// ----- rtl/servo_write_packet_framer.sv -----
// Top level: servo bus write packet framer with APB register port.
// Set id: loaded straight from idle, then 8 bytes, one per accepted word.
// Set position and set baud: the serial divider (none at baud 0), then 9 or 8 bytes.
// One command at a time; the next command is taken the cycle after the checksum leaves.
// Reset (arst_n low, asynchronous): idle, no word pending, motor_id back to 1.
// Throughput is set by the 25-step divider plus one output byte per unstalled cycle.
module servo_write_packet_framer import swpf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic cmd_valid,
	output logic cmd_stall,
	input logic [1:0] action,
	input logic [14:0] angle_centideg,
	input logic [20:0] baud_rate,
	input logic [7:0] new_id,
	output logic pkt_valid,
	input logic pkt_stall,
	output logic [7:0] tx_byte,
	output logic last_byte
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV = 3'b010,
		ST_SEND = 3'b100
	} state_t;

	state_t state_q;
	logic [7:0] motor_id_q;
	logic [1:0] act_q;
	logic cmd_take;
	logic div_start;
	logic [DVD_W-1:0] dvd;
	logic [DVS_W-1:0] dvs;
	logic div_done;
	logic [DVD_W-1:0] quo;
	logic [DVD_W-1:0] quo_m1;
	logic [15:0] word;
	logic [7:0] code;
	logic [9:0] pos;
	logic ser_load;
	pkt_load_t load_info;
	logic ser_done;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MOTOR_ID) ? {24'b0, motor_id_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motor_id_q <= MOTOR_ID_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MOTOR_ID)) begin
			motor_id_q <= pwdata[7:0];
		end
	end

	assign cmd_stall = (state_q != ST_IDLE);
	assign cmd_take = cmd_valid && !cmd_stall;
	assign div_start = cmd_take && ((action == ACT_POS) ||
		((action == ACT_BAUD) && (baud_rate != '0)));

	always_comb begin
		if (action == ACT_POS) begin
			dvd = {angle_centideg, 10'b0} - {10'b0, angle_centideg};
			dvs = POS_DIVISOR;
		end else begin
			dvd = BAUD_NUM;
			dvs = baud_rate;
		end
	end

	swpf_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(dvd),
		.divisor(dvs),
		.done(div_done),
		.quotient(quo)
	);

	assign quo_m1 = quo - DVD_W'(1);
	assign pos = (quo > {15'b0, POS_MAX}) ? POS_MAX : quo[9:0];

	always_comb begin
		if (quo == '0) begin
			code = 8'd0;
		end else if (quo_m1 > {17'b0, CODE_MAX}) begin
			code = CODE_MAX;
		end else begin
			code = quo_m1[7:0];
		end
	end

	always_comb begin
		load_info.id = motor_id_q;
		load_info.two_data = 1'b0;
		load_info.addr = ADDR_ID;
		word = {8'b0, new_id};
		ser_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_take && (action == ACT_ID)) begin
					ser_load = 1'b1;
				end else if (cmd_take && (action == ACT_BAUD)) begin
					ser_load = (baud_rate == '0);
					load_info.addr = ADDR_BAUD;
					word = {8'b0, CODE_DEFAULT};
				end
			end
			ST_DIV: begin
				ser_load = div_done;
				if (act_q == ACT_POS) begin
					load_info.two_data = 1'b1;
					load_info.addr = ADDR_GOAL;
					word = {6'b0, pos};
				end else begin
					load_info.addr = ADDR_BAUD;
					word = {8'b0, code};
				end
			end
			ST_SEND: begin
				ser_load = 1'b0;
			end
			default: begin
				ser_load = 1'b0;
			end
		endcase
		load_info.data0 = word[7:0];
		load_info.data1 = word[15:8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			act_q <= ACT_NONE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					act_q <= action;
					if (div_start) begin
						state_q <= ST_DIV;
					end else if (ser_load) begin
						state_q <= ST_SEND;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_SEND;
					end
				end
				ST_SEND: begin
					if (ser_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	swpf_ser u_ser (
		.clk(clk),
		.arst_n(arst_n),
		.load(ser_load),
		.load_info(load_info),
		.pkt_valid(pkt_valid),
		.pkt_stall(pkt_stall),
		.tx_byte(tx_byte),
		.last_byte(last_byte),
		.done(ser_done)
	);

endmodule

// ----- rtl/swpf_chk.sv -----
// Port checker of the servo write packet framer and its bind.
module swpf_chk import swpf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_stall,
	input logic [1:0] action,
	input logic pkt_valid,
	input logic pkt_stall,
	input logic [7:0] tx_byte,
	input logic last_byte
);

	a_idle_no_word: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_stall |-> !pkt_valid)
		else $error("packet word shown while taking commands");

	a_cmd_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall && (action != ACT_NONE)) |=> cmd_stall)
		else $error("command taken without going busy");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(pkt_valid && !pkt_stall && last_byte) |=> !pkt_valid)
		else $error("word shown after checksum word");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(pkt_valid && pkt_stall) |=> (pkt_valid && $stable(tx_byte) && $stable(last_byte)))
		else $error("stalled packet word changed");

endmodule

bind servo_write_packet_framer swpf_chk u_chk (.*);

// ----- dv/servo_write_packet_framer_test.sv -----
// Self-checking testbench of the servo write packet framer: commands, register writes, byte checks.
module servo_write_packet_framer_test import swpf_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] MOTOR_ID_ADDR = 3'(4 * REG_MOTOR_ID);
	localparam logic [2:0] UNUSED_REG_ADDR = 3'd4;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 40;
	localparam int LONG_HOLD_CYCLES = 200;

	class packet_scoreboard;
		typedef struct packed {
			logic [7:0] data;
			logic last;
		} tx_word_t;

		tx_word_t expected_q[$];
		logic [7:0] motor_id;
		int errors;
		int pos_cmds;
		int baud_cmds;
		int id_cmds;
		int ignored_cmds;
		int words_checked;

		function new();
			motor_id = MOTOR_ID_RESET;
			errors = 0;
			pos_cmds = 0;
			baud_cmds = 0;
			id_cmds = 0;
			ignored_cmds = 0;
			words_checked = 0;
		endfunction

		function void note_register(logic [2:0] addr, logic [31:0] data);
			if (addr == MOTOR_ID_ADDR)
				motor_id = data[7:0];
		endfunction

		function void note_command(logic [1:0] act, logic [14:0] angle,
				logic [20:0] rate, logic [7:0] nid);
			logic [31:0] scaled;
			logic [31:0] quotient;
			logic [9:0] pos;
			logic [7:0] code;
			logic [7:0] addr;
			logic [7:0] sum;
			logic [7:0] pkt[$];
			tx_word_t word;
			case (act)
				ACT_POS: begin
					scaled = (32'(angle) * 32'(POS_MAX)) / 32'(POS_DIVISOR);
					pos = (scaled > 32'(POS_MAX)) ? POS_MAX : scaled[9:0];
					addr = ADDR_GOAL;
					pos_cmds++;
				end
				ACT_BAUD: begin
					if (rate == '0) begin
						code = CODE_DEFAULT;
					end else begin
						quotient = 32'(BAUD_NUM) / 32'(rate);
						if (quotient == 0)
							code = 8'd0;
						else if (quotient - 1 > 32'(CODE_MAX))
							code = CODE_MAX;
						else
							code = quotient[7:0] - 8'd1;
					end
					addr = ADDR_BAUD;
					baud_cmds++;
				end
				ACT_ID: begin
					addr = ADDR_ID;
					id_cmds++;
				end
				default: begin
					ignored_cmds++;
					return;
				end
			endcase
			pkt.push_back(HDR_BYTE);
			pkt.push_back(HDR_BYTE);
			pkt.push_back(motor_id);
			pkt.push_back(act == ACT_POS ? LEN_TWO : LEN_ONE);
			pkt.push_back(OP_WRITE);
			pkt.push_back(addr);
			case (act)
				ACT_POS: begin
					pkt.push_back(pos[7:0]);
					pkt.push_back({6'd0, pos[9:8]});
				end
				ACT_BAUD: pkt.push_back(code);
				default: pkt.push_back(nid);
			endcase
			sum = 8'd0;
			for (int i = 2; i < pkt.size(); i++)
				sum = sum + pkt[i];
			pkt.push_back(~sum);
			foreach (pkt[i]) begin
				word.data = pkt[i];
				word.last = (i == pkt.size() - 1);
				expected_q.push_back(word);
			end
		endfunction

		function void check_word(logic [7:0] data, logic last);
			tx_word_t want;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected byte, expected none, actual %02h last %0b",
					$time, data, last);
				return;
			end
			want = expected_q.pop_front();
			words_checked++;
			if (data !== want.data) begin
				errors++;
				$display("%0t: tx_byte expected %02h actual %02h", $time, want.data, data);
			end
			if (last !== want.last) begin
				errors++;
				$display("%0t: last_byte expected %0b actual %0b", $time, want.last, last);
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic cmd_valid;
	logic cmd_stall;
	logic [1:0] action;
	logic [14:0] angle_centideg;
	logic [20:0] baud_rate;
	logic [7:0] new_id;
	logic pkt_valid;
	logic pkt_stall;
	logic [7:0] tx_byte;
	logic last_byte;

	packet_scoreboard sb = new();
	bit tx_idling = 1'b1;
	bit rx_idling = 1'b1;
	int long_hold = 0;
	int cycles = 0;

	servo_write_packet_framer u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.action(action),
		.angle_centideg(angle_centideg),
		.baud_rate(baud_rate),
		.new_id(new_id),
		.pkt_valid(pkt_valid),
		.pkt_stall(pkt_stall),
		.tx_byte(tx_byte),
		.last_byte(last_byte)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("servo_write_packet_framer verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && pkt_valid && !pkt_stall)
			sb.check_word(tx_byte, last_byte);
	end

	initial begin
		pkt_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold > 0) begin
				pkt_stall <= 1'b1;
				repeat (long_hold) @(posedge clk);
				long_hold = 0;
				pkt_stall <= 1'b0;
			end else if (rx_idling && $urandom_range(0, 5) == 0) begin
				pkt_stall <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				pkt_stall <= 1'b0;
			end
		end
	end

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.note_register(addr, data);
	endtask

	task automatic offer_command(input logic [1:0] act, input logic [14:0] angle,
			input logic [20:0] rate, input logic [7:0] nid);
		if (tx_idling && $urandom_range(0, 3) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		action <= act;
		angle_centideg <= angle;
		baud_rate <= rate;
		new_id <= nid;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		sb.note_command(act, angle, rate, nid);
	endtask

	task automatic wait_drained();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_commands(input int count);
		int real_cmds;
		logic [1:0] act;
		logic [14:0] angle;
		logic [20:0] rate;
		real_cmds = 0;
		while (real_cmds < count) begin
			act = ($urandom_range(0, 11) == 0) ? ACT_NONE : 2'($urandom_range(0, 2));
			case ($urandom_range(0, 3))
				0: angle = 15'($urandom_range(0, 30000));
				1: angle = 15'($urandom_range(0, 32767));
				2: angle = 15'($urandom_range(29900, 30100));
				default: angle = 15'($urandom_range(0, 40));
			endcase
			case ($urandom_range(0, 4))
				0: rate = 21'($urandom_range(0, 2097151));
				1: rate = 21'($urandom_range(1, 8000));
				2: rate = 21'($urandom_range(9000, 1100000));
				3: rate = 21'($urandom_range(0, 3));
				default: rate = 21'($urandom_range(1990000, 2097151));
			endcase
			offer_command(act, angle, rate, 8'($urandom_range(0, 255)));
			if (act != ACT_NONE)
				real_cmds++;
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		cmd_valid <= 1'b0;
		action <= ACT_POS;
		angle_centideg <= '0;
		baud_rate <= '0;
		new_id <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer_command(ACT_POS, 15'd0, 21'($urandom), 8'($urandom));
		offer_command(ACT_POS, 15'd30000, 21'($urandom), 8'($urandom));
		offer_command(ACT_POS, 15'd32767, 21'($urandom), 8'($urandom));
		offer_command(ACT_POS, 15'd29, 21'($urandom), 8'($urandom));
		offer_command(ACT_POS, 15'd15000, 21'($urandom), 8'($urandom));
		offer_command(ACT_POS, 15'd30001, 21'($urandom), 8'($urandom));
		offer_command(ACT_BAUD, 15'($urandom), 21'd0, 8'($urandom));
		offer_command(ACT_BAUD, 15'($urandom), 21'd1, 8'($urandom));
		offer_command(ACT_BAUD, 15'($urandom), 21'd2000000, 8'($urandom));
		offer_command(ACT_BAUD, 15'($urandom), 21'd2097151, 8'($urandom));
		offer_command(ACT_BAUD, 15'($urandom), 21'd7843, 8'($urandom));
		offer_command(ACT_BAUD, 15'($urandom), 21'd7812, 8'($urandom));
		offer_command(ACT_BAUD, 15'($urandom), 21'd1000000, 8'($urandom));
		offer_command(ACT_BAUD, 15'($urandom), 21'd1000001, 8'($urandom));
		offer_command(ACT_ID, 15'($urandom), 21'($urandom), 8'd0);
		offer_command(ACT_ID, 15'($urandom), 21'($urandom), 8'd255);
		offer_command(ACT_ID, 15'($urandom), 21'($urandom), 8'hAA);
		offer_command(ACT_NONE, 15'($urandom), 21'($urandom), 8'($urandom));
		offer_command(ACT_NONE, 15'h7fff, 21'h1fffff, 8'hff);
		offer_command(ACT_ID, 15'($urandom), 21'($urandom), 8'h55);
		wait_drained();

		apb_write(MOTOR_ID_ADDR, 32'd0);
		long_hold = LONG_HOLD_CYCLES;
		random_commands(100);
		wait_drained();

		apb_write(UNUSED_REG_ADDR, $urandom);
		apb_write(MOTOR_ID_ADDR, 32'd254);
		random_commands(100);
		wait_drained();

		apb_write(MOTOR_ID_ADDR, 32'($urandom_range(0, 254)));
		random_commands(80);
		tx_idling = 1'b0;
		rx_idling = 1'b0;
		random_commands(60);
		wait_drained();

		$display("covered %0d position, %0d baud and %0d id commands plus %0d ignored codes",
			sb.pos_cmds, sb.baud_cmds, sb.id_cmds, sb.ignored_cmds);
		$display("checked %0d packet bytes over four motor id settings and a long output hold",
			sb.words_checked);
		if (sb.errors == 0)
			$display("servo_write_packet_framer verification clean");
		else
			$display("servo_write_packet_framer verification failed");
		$finish;
	end

endmodule

// ----- servo_write_packet_framer.f -----
rtl/swpf_pkg.sv
rtl/swpf_div.sv
rtl/swpf_ser.sv
rtl/servo_write_packet_framer.sv
rtl/swpf_chk.sv
dv/servo_write_packet_framer_test.sv
